// ===== hdl/amow_pkg.sv =====
`timescale 1ns / 1ps
package amow_pkg;
    localparam int WB = 32;
    localparam int FB = 24;
    localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
    localparam logic signed [WB-1:0] FX_ONE = WB'(64'd1 << FB);
    localparam logic signed [WB-1:0] FX_HALF = WB'(64'd1 << (FB - 1));
    localparam logic signed [WB-1:0] FX_HI = WB'((64'd1 << (FB - 1)) + (64'd1 << FB) / 10000);

    localparam logic [1:0] REG_KIND = 2'd0;
    localparam logic [1:0] REG_A    = 2'd1;
    localparam logic [1:0] REG_B    = 2'd2;
    localparam logic [1:0] REG_PER  = 2'd3;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [WB-1:0] a;
        logic signed [WB-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic signed [WB-1:0] res;
        logic                 sat;
    } t_alu_rsp;

    function automatic logic signed [WB-1:0] coef_fx(input logic [2:0] idx);
        logic [31:0] q;
        case (idx)
            3'd0: q = 32'd1686629713;
            3'd1: q = 32'd693598669;
            3'd2: q = 32'd85569306;
            3'd3: q = 32'd5026995;
            3'd4: q = 32'd172272;
            default: q = 32'd3864;
        endcase
        return WB'(q >> (30 - FB));
    endfunction
endpackage

// ===== hdl/amow_alu.sv =====
`timescale 1ns / 1ps
module amow_alu (
    input  logic                i_clk,
    input  amow_pkg::t_alu_req  i_req,
    output amow_pkg::t_alu_rsp  o_rsp
);
    localparam int WB = amow_pkg::WB;
    localparam int FB = amow_pkg::FB;
    logic [WB-1:0]   w_ma, w_mb;
    logic [2*WB-1:0] w_prod;
    logic [2*WB-1:0] w_mag;
    logic            w_neg;
    logic signed [WB:0] w_sum;
    amow_pkg::t_alu_rsp n_rsp;

    assign w_ma = i_req.a[WB-1] ? WB'(-i_req.a) : i_req.a;
    assign w_mb = i_req.b[WB-1] ? WB'(-i_req.b) : i_req.b;
    assign w_neg = i_req.a[WB-1] ^ i_req.b[WB-1];
    assign w_prod = w_ma * w_mb;
    assign w_mag = w_prod >> FB;

    always_comb begin
        n_rsp.sat = 1'b0;
        n_rsp.res = '0;
        w_sum = '0;
        case (i_req.op)
            amow_pkg::OP_MUL: begin
                if (!w_neg) begin
                    if (w_mag > (2*WB)'(amow_pkg::W_MAX)) begin
                        n_rsp.sat = 1'b1;
                        n_rsp.res = amow_pkg::W_MAX;
                    end else begin
                        n_rsp.res = w_mag[WB-1:0];
                    end
                end else begin
                    if (w_mag > (2*WB)'(amow_pkg::W_MAX) + 1) begin
                        n_rsp.sat = 1'b1;
                        n_rsp.res = amow_pkg::W_MIN;
                    end else begin
                        n_rsp.res = WB'(-w_mag[WB-1:0]);
                    end
                end
            end
            amow_pkg::OP_ADD, amow_pkg::OP_SUB: begin
                if (i_req.op == amow_pkg::OP_ADD) begin
                    w_sum = {i_req.a[WB-1], i_req.a} + {i_req.b[WB-1], i_req.b};
                end else begin
                    w_sum = {i_req.a[WB-1], i_req.a} - {i_req.b[WB-1], i_req.b};
                end
                if (w_sum[WB] != w_sum[WB-1]) begin
                    n_rsp.sat = 1'b1;
                    n_rsp.res = w_sum[WB] ? amow_pkg::W_MIN : amow_pkg::W_MAX;
                end else begin
                    n_rsp.res = w_sum[WB-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_rsp <= n_rsp;
    end
endmodule

// ===== hdl/area_map_orbit_winding_top.sv =====
`timescale 1ns / 1ps
// channel   ports                                   handshake
// config    i_cfg_we i_cfg_idx i_cfg_data           write at edge with i_cfg_we
// input     i_start_x i_start_y                     i_start & !o_busy
// result    o_end_x o_end_y o_lift o_drift_x        o_done, one cycle
//           o_drift_y o_overflow
// One registered multiply/add unit does the sine and map arithmetic; the fold is
// combinational. Each op result shows up the cycle after issue. A Harper step
// takes two sines, a nontwist step one sine and a square; a new word is taken
// in the done cycle.
// Reset (i_rst_n low, synchronous) clears control; the result cannot be stalled.
module area_map_orbit_winding_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_start,
    output logic         o_busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    output logic         o_done,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic signed [15:0] o_lift,
    output logic signed [31:0] o_drift_x,
    output logic signed [31:0] o_drift_y,
    output logic         o_overflow
);
    localparam int WB = amow_pkg::WB;
    localparam int FB = amow_pkg::FB;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_STEP  = 5'd1;
    localparam logic [4:0] S_SIN0  = 5'd2;
    localparam logic [4:0] S_SIN1  = 5'd3;
    localparam logic [4:0] S_HORN0 = 5'd4;
    localparam logic [4:0] S_HORN1 = 5'd5;
    localparam logic [4:0] S_HORN2 = 5'd6;
    localparam logic [4:0] S_SIN2  = 5'd7;
    localparam logic [4:0] S_SIN3  = 5'd8;
    localparam logic [4:0] S_PM0   = 5'd9;
    localparam logic [4:0] S_PM1   = 5'd10;
    localparam logic [4:0] S_UPD0  = 5'd11;
    localparam logic [4:0] S_UPD1  = 5'd12;
    localparam logic [4:0] S_FOLD  = 5'd13;
    localparam logic [4:0] S_DX0   = 5'd14;
    localparam logic [4:0] S_DX1   = 5'd15;
    localparam logic [4:0] S_DY0   = 5'd16;
    localparam logic [4:0] S_DY1   = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;
    localparam logic [4:0] S_NT0   = 5'd19;
    localparam logic [4:0] S_NT1   = 5'd20;
    localparam logic [4:0] S_NT2   = 5'd21;

    logic [4:0] r_st, n_st;
    logic       r_kind;
    logic signed [WB-1:0] r_a, r_b;
    logic [15:0] r_per, r_cnt;
    logic signed [WB-1:0] r_x, r_y, r_ox, r_oy;
    logic signed [16:0] r_lift;
    logic r_sat;
    // phase: 0 = sine of x toward y, 1 = sine of y (Harper) or 1 - y*y (nontwist) toward x
    logic r_ph;
    logic [1:0] r_quad;
    logic signed [WB-1:0] r_u, r_u2, r_acc, r_t;
    logic [2:0] r_idx;
    logic signed [WB-1:0] r_dx;
    logic r_done;

    amow_pkg::t_alu_req w_req;
    amow_pkg::t_alu_rsp w_rsp;

    amow_alu u_alu (.i_clk(i_clk), .i_req(w_req), .o_rsp(w_rsp));

    localparam logic [WB-1:0] FX_ONE_U = amow_pkg::FX_ONE;
    logic signed [WB-1:0] w_sv;
    logic [WB-1:0] w_ph;
    logic [WB-1:0] w_uraw;
    logic [WB-1:0] w_u;
    assign w_sv = r_ph ? r_y : r_x;
    assign w_ph = w_sv & (FX_ONE_U - 1);
    assign w_uraw = (w_ph & ((WB'(1) << (FB - 2)) - 1)) << 2;
    assign w_u = w_ph[FB-2] ? FX_ONE_U - w_uraw : w_uraw;

    // fold: v > HI -> HI - rem, v < -HALF -> -HALF + rem, k = +-ceil(d/ONE); power-of-two ONE makes it masks
    function automatic logic [WB+16:0] fold_f(input logic signed [WB-1:0] v);
        logic [WB-1:0] d, rem, km;
        logic [WB-FB-1:0] q;
        logic signed [WB-1:0] o;
        logic signed [16:0] k;
        d = '0; rem = '0; km = '0; q = '0; o = v; k = '0;
        if (v > amow_pkg::FX_HI) begin
            d = WB'(v - amow_pkg::FX_HI);
            km = d & (FX_ONE_U - 1);
            rem = (km == 0) ? '0 : FX_ONE_U - km;
            q = d[WB-1:FB];
            k = 17'(q) + 17'(km != 0);
            o = amow_pkg::FX_HI - rem;
        end else if (v < -amow_pkg::FX_HALF) begin
            d = WB'(-amow_pkg::FX_HALF - v);
            km = d & (FX_ONE_U - 1);
            rem = (km == 0) ? '0 : FX_ONE_U - km;
            q = d[WB-1:FB];
            k = -(17'(q) + 17'(km != 0));
            o = -amow_pkg::FX_HALF + rem;
        end
        return {k, o};
    endfunction

    logic [WB+16:0] w_fx, w_fy;
    logic signed [17:0] w_nl;
    assign w_fx = fold_f(r_x);
    assign w_fy = fold_f(r_y);
    assign w_nl = 18'(r_lift) + 18'($signed(w_fx[WB+16:WB]));

    always_comb begin
        w_req.op = amow_pkg::OP_MUL;
        w_req.a = r_u;
        w_req.b = r_u;
        case (r_st)
            S_SIN0:  begin w_req.a = w_u; w_req.b = w_u; end
            S_HORN0: begin w_req.a = r_u2; w_req.b = r_acc; end
            S_HORN1: begin
                w_req.op = amow_pkg::OP_SUB;
                w_req.a = amow_pkg::coef_fx(r_idx);
                w_req.b = w_rsp.res;
            end
            S_SIN2:  begin w_req.a = r_u; w_req.b = r_acc; end
            S_PM0:   begin w_req.a = r_ph ? r_a : r_b; w_req.b = r_t; end
            S_UPD0:  begin
                w_req.a = r_ph ? r_x : r_y;
                w_req.b = r_t;
                w_req.op = ((r_ph == 1'b0) ^ r_kind) ? amow_pkg::OP_ADD
                                                     : amow_pkg::OP_SUB;
            end
            S_NT0:   begin w_req.a = r_y; w_req.b = r_y; end
            S_NT1:   begin
                w_req.op = amow_pkg::OP_SUB;
                w_req.a = amow_pkg::FX_ONE;
                w_req.b = w_rsp.res;
            end
            S_DX0:   begin w_req.op = amow_pkg::OP_SUB; w_req.a = r_x; w_req.b = r_ox; end
            S_DY0:   begin w_req.op = amow_pkg::OP_SUB; w_req.a = r_y; w_req.b = r_oy; end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_start) n_st = S_STEP;
            S_STEP:  n_st = (r_cnt == r_per) ? S_DX0 : S_SIN0;
            S_SIN0:  n_st = S_SIN1;
            S_SIN1:  n_st = S_HORN0;
            S_HORN0: n_st = S_HORN1;
            S_HORN1: n_st = S_HORN2;
            S_HORN2: n_st = (r_idx == 3'd0) ? S_SIN2 : S_HORN0;
            S_SIN2:  n_st = S_SIN3;
            S_SIN3:  n_st = S_PM0;
            S_PM0:   n_st = S_PM1;
            S_PM1:   n_st = S_UPD0;
            S_UPD0:  n_st = S_UPD1;
            S_UPD1:  n_st = (r_ph || r_kind) ? ((r_ph) ? S_FOLD : S_NT0) : S_SIN0;
            S_NT0:   n_st = S_NT1;
            S_NT1:   n_st = S_NT2;
            S_NT2:   n_st = S_PM0;
            S_FOLD:  n_st = S_STEP;
            S_DX0:   n_st = S_DX1;
            S_DX1:   n_st = S_DY0;
            S_DY0:   n_st = S_DY1;
            S_DY1:   n_st = S_OUT;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_kind <= 1'b0;
            r_a <= '0;
            r_b <= '0;
            r_per <= 16'd1;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_done <= (r_st == S_OUT);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    amow_pkg::REG_KIND: r_kind <= i_cfg_data[0];
                    amow_pkg::REG_A:    r_a <= i_cfg_data;
                    amow_pkg::REG_B:    r_b <= i_cfg_data;
                    amow_pkg::REG_PER:  r_per <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (i_start) begin
                r_x <= i_start_x; r_y <= i_start_y;
                r_ox <= i_start_x; r_oy <= i_start_y;
                r_lift <= '0; r_sat <= 1'b0; r_cnt <= '0; r_ph <= 1'b0;
            end
            S_SIN0: begin
                r_quad <= w_ph[FB-1:FB-2];
                r_u <= w_u;
                r_acc <= amow_pkg::coef_fx(3'd5);
                r_idx <= 3'd4;
            end
            S_SIN1: begin r_u2 <= w_rsp.res; r_sat <= r_sat | w_rsp.sat; end
            S_HORN1: r_sat <= r_sat | w_rsp.sat;
            S_HORN2: begin
                r_acc <= w_rsp.res; r_sat <= r_sat | w_rsp.sat;
                r_idx <= r_idx - 3'd1;
            end
            S_SIN3: begin
                r_sat <= r_sat | w_rsp.sat;
                r_t <= (w_rsp.res > amow_pkg::FX_ONE)
                    ? (r_quad[1] ? -amow_pkg::FX_ONE : amow_pkg::FX_ONE)
                    : (r_quad[1] ? -w_rsp.res : w_rsp.res);
            end
            S_NT1: r_sat <= r_sat | w_rsp.sat;
            S_NT2: begin r_t <= w_rsp.res; r_sat <= r_sat | w_rsp.sat; end
            S_PM1: begin r_t <= w_rsp.res; r_sat <= r_sat | w_rsp.sat; end
            S_UPD1: begin
                r_sat <= r_sat | w_rsp.sat;
                if (r_ph) r_x <= w_rsp.res; else r_y <= w_rsp.res;
                r_ph <= ~r_ph;
            end
            S_FOLD: begin
                r_x <= w_fx[WB-1:0];
                if (!r_kind) r_y <= w_fy[WB-1:0];
                if (w_nl > 18'sd32767) begin
                    r_lift <= 17'sd32767; r_sat <= 1'b1;
                end else if (w_nl < -18'sd32768) begin
                    r_lift <= -17'sd32768; r_sat <= 1'b1;
                end else begin
                    r_lift <= w_nl[16:0];
                end
                r_cnt <= r_cnt + 16'd1;
            end
            S_DX1: r_dx <= w_rsp.res;
            S_DY1: r_t <= w_rsp.res;
            S_OUT: begin
                o_end_x <= r_x; o_end_y <= r_y; o_lift <= r_lift[15:0];
                o_drift_x <= r_dx; o_drift_y <= r_t; o_overflow <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy || $past(i_start)) else $error("busy at done");
    a_lift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_lift <= 17'sd32767 && r_lift >= -17'sd32768))
        else $error("lift range");
`endif
endmodule

// ===== tb/area_map_orbit_winding_top_test.sv =====
`timescale 1ns / 1ps
module area_map_orbit_winding_top_test;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd1 << 24;
    localparam longint HALF = 64'sd1 << 23;
    localparam longint HI   = (64'sd1 << 23) + (64'sd1 << 24) / 10000;
    localparam int     WATCHDOG = 16000000;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_word;

    typedef struct {
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [15:0] lift;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               ovf;
    } t_orbit;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_start = 0;
    logic signed [31:0] i_start_x = '0;
    logic signed [31:0] i_start_y = '0;
    logic        o_busy, o_done, o_overflow;
    logic signed [31:0] o_end_x, o_end_y, o_drift_x, o_drift_y;
    logic signed [15:0] o_lift;

    area_map_orbit_winding_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic        m_kind = 0;
    longint      m_a = 0, m_b = 0;
    int          m_period = 1;
    bit          sat_flag;
    int          lift_acc;

    t_word  pending_words[$];
    t_orbit expected_orbits[$];
    int     errors = 0;
    int     orbits_checked = 0;
    int     words_sent = 0;
    int     idle_pct = 0;
    int     idle_cycles = 0;
    bit     hold_off = 0;

    function automatic longint s_add(longint u, longint v);
        if (v > 0 && u > WMAX - v) begin sat_flag = 1; return WMAX; end
        if (v < 0 && u < WMIN - v) begin sat_flag = 1; return WMIN; end
        return u + v;
    endfunction

    function automatic longint s_sub(longint u, longint v);
        if (v < 0 && u > WMAX + v) begin sat_flag = 1; return WMAX; end
        if (v > 0 && u < WMIN + v) begin sat_flag = 1; return WMIN; end
        return u - v;
    endfunction

    function automatic longint q_mul(longint u, longint v);
        bit neg;
        logic [63:0] mu, mv, mag;
        logic [127:0] p;
        neg = (u < 0) != (v < 0);
        mu = u < 0 ? -u : u;
        mv = v < 0 ? -v : v;
        p = mu * mv;
        mag = p[87:24];
        if (!neg) begin
            if (p[127:88] != 0 || mag > WMAX) begin sat_flag = 1; return WMAX; end
            return mag;
        end
        if (p[127:88] != 0 || mag > 64'd2147483648) begin sat_flag = 1; return WMIN; end
        return -longint'(mag);
    endfunction

    function automatic longint sin_coef(int idx);
        longint q[6] = '{1686629713, 693598669, 85569306, 5026995, 172272, 3864};
        return q[idx] >>> 6;
    endfunction

    function automatic longint turn_sin(longint v);
        logic [63:0] ph;
        int quad;
        longint u, u2, acc;
        ph = v & (ONE - 1);
        quad = int'(ph[23:22]);
        u = longint'({ph[21:0], 2'b00});
        if (quad & 1) u = ONE - u;
        u2 = q_mul(u, u);
        acc = sin_coef(5);
        for (int i = 4; i >= 0; i--) acc = s_sub(sin_coef(i), q_mul(u2, acc));
        acc = q_mul(u, acc);
        if (acc > ONE) acc = ONE;
        return (quad & 2) ? -acc : acc;
    endfunction

    function automatic void move_lift(longint cnt, bit up);
        longint nv;
        if (cnt > 65536) cnt = 65536;
        nv = up ? lift_acc + cnt : lift_acc - cnt;
        if (nv > 32767) begin nv = 32767; sat_flag = 1; end
        if (nv < -32768) begin nv = -32768; sat_flag = 1; end
        lift_acc = int'(nv);
    endfunction

    function automatic longint wrap(longint v, bit count);
        longint d, rem;
        if (v > HI) begin
            d = v - HI;
            rem = (ONE - d % ONE) % ONE;
            if (count) move_lift(d / ONE + (rem != 0), 1);
            return HI - rem;
        end
        if (v < -HALF) begin
            d = -HALF - v;
            rem = (ONE - d % ONE) % ONE;
            if (count) move_lift(d / ONE + (rem != 0), 0);
            return -HALF + rem;
        end
        return v;
    endfunction

    function automatic t_orbit run_orbit(t_word w);
        t_orbit r;
        longint x, y;
        x = w.sx;
        y = w.sy;
        lift_acc = 0;
        sat_flag = 0;
        for (int n = 0; n < m_period; n++) begin
            if (!m_kind) begin
                y = s_add(y, q_mul(m_b, turn_sin(x)));
                x = s_sub(x, q_mul(m_a, turn_sin(y)));
                x = wrap(x, 1);
                y = wrap(y, 0);
            end else begin
                y = s_sub(y, q_mul(m_b, turn_sin(x)));
                x = s_add(x, q_mul(m_a, s_sub(ONE, q_mul(y, y))));
                x = wrap(x, 1);
            end
        end
        r.ovf = sat_flag;
        r.ex = 32'(x);
        r.ey = 32'(y);
        r.lift = 16'(lift_acc);
        r.dx = 32'(s_sub(x, w.sx));
        r.dy = 32'(s_sub(y, w.sy));
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                expected_orbits.push_back(run_orbit(pending_words.pop_front()));
                words_sent++;
                idle_cycles = 0;
            end
            if ((i_start && !o_busy) || !i_start) begin
                if (pending_words.size() > 0 && !hold_off &&
                    $urandom_range(99) >= idle_pct) begin
                    i_start <= 1;
                    i_start_x <= pending_words[0].sx;
                    i_start_y <= pending_words[0].sy;
                end else begin
                    i_start <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_orbit e;
        if (i_rst_n && o_done) begin
            idle_cycles = 0;
            if (expected_orbits.size() == 0) begin
                $display("%0t unexpected result end_x=%h", $time, o_end_x);
                errors++;
            end else begin
                e = expected_orbits.pop_front();
                orbits_checked++;
                if (o_end_x !== e.ex || o_end_y !== e.ey || o_lift !== e.lift ||
                    o_drift_x !== e.dx || o_drift_y !== e.dy || o_overflow !== e.ovf) begin
                    $display("%0t mismatch exp x=%h y=%h l=%h dx=%h dy=%h ov=%b",
                             $time, e.ex, e.ey, e.lift, e.dx, e.dy, e.ovf);
                    $display("%0t          got x=%h y=%h l=%h dx=%h dy=%h ov=%b",
                             $time, o_end_x, o_end_y, o_lift, o_drift_x, o_drift_y,
                             o_overflow);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles > WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            amow_pkg::REG_KIND: m_kind = val[0];
            amow_pkg::REG_A:    m_a = longint'($signed(val));
            amow_pkg::REG_B:    m_b = longint'($signed(val));
            default:            m_period = int'(val[15:0]);
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !i_start);
        wait (expected_orbits.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_word(logic [31:0] x, logic [31:0] y);
        t_word w;
        w.sx = x;
        w.sy = y;
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            2: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                              : 32'h8000_0000 + $urandom_range(3);
        endcase
    endfunction

    function automatic logic [31:0] rnd_coef();
        case ($urandom_range(3))
            0: return $urandom();
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    initial begin
        int idle_mix[4] = '{0, 86, 0, 27};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: Harper with default coefficients, then extremes
        add_word(32'h0, 32'h0);
        add_word(32'h7fff_ffff, 32'h8000_0000);
        add_word(32'h8000_0000, 32'h7fff_ffff);
        drain();
        write_reg(amow_pkg::REG_PER, 0);
        add_word(32'h1234_5678, 32'hfedc_ba98);
        drain();
        write_reg(amow_pkg::REG_KIND, 0);
        write_reg(amow_pkg::REG_A, 32'h7fff_ffff);
        write_reg(amow_pkg::REG_B, 32'h8000_0000);
        write_reg(amow_pkg::REG_PER, 3);
        add_word(32'h0040_0000, 32'h0);
        add_word(32'h0080_0000 + 32'd1678, 32'hff80_0000);
        add_word(32'h7fff_ffff, 32'h7fff_ffff);
        add_word(32'h0020_0000, 32'h0060_0000);
        drain();
        write_reg(amow_pkg::REG_KIND, 32'hffff_fffe);
        add_word(32'h0010_0000, 32'h0010_0000);
        drain();
        write_reg(amow_pkg::REG_KIND, 1);
        write_reg(amow_pkg::REG_A, 32'h0100_0000);
        write_reg(amow_pkg::REG_B, 32'h0080_0000);
        write_reg(amow_pkg::REG_PER, 4);
        add_word(32'h0, 32'h0);
        add_word(32'h8000_0000, 32'h8000_0000);
        add_word(32'h7fff_ffff, 32'h0100_0000);
        add_word(32'h0030_0000, 32'hffd0_0000);
        drain();
        // lift saturation: huge a drives x fold counts up fast
        write_reg(amow_pkg::REG_A, 32'h7fff_ffff);
        write_reg(amow_pkg::REG_PER, 8);
        add_word(32'h0, 32'h0);
        add_word(32'h0, 32'h0300_0000);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = idle_mix[ph % 4];
            write_reg(amow_pkg::REG_KIND, $urandom());
            write_reg(amow_pkg::REG_A, rnd_coef());
            write_reg(amow_pkg::REG_B, rnd_coef());
            write_reg(amow_pkg::REG_PER, (ph == 7) ? 32'hffff_ffff : $urandom_range(1, 12));
            for (int k = 0; k < ((ph == 7) ? 1 : 16); k++) add_word(rnd_coord(), rnd_coord());
            if (ph == 3) begin
                wait (pending_words.size() < 8);
                hold_off = 1;
                wait (expected_orbits.size() == 0);
                hold_off = 0;
            end
            drain();
        end
        write_reg(amow_pkg::REG_PER, 1);
        idle_pct = 0;
        for (int k = 0; k < 16; k++) add_word($urandom(), $urandom());
        drain();

        $display("Covered %0d orbits (%0d words sent) over both map kinds,", orbits_checked,
                 words_sent);
        $display("periods 0..65535, extreme coefficients and start points.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/amow_pkg.sv
hdl/amow_alu.sv
hdl/area_map_orbit_winding_top.sv
tb/area_map_orbit_winding_top_test.sv
